FILE: rtl/core/gbfc_pkg.sv
// Shared constants and types for the glyph binarize, filter and classify block.
package gbfc_pkg;

	localparam int IMG_WIDTH_DEF    = 64;
	localparam int IMG_HEIGHT_DEF   = 32;
	localparam int GLYPH_WIDTH_DEF  = 12;
	localparam int GLYPH_HEIGHT_DEF = 16;
	localparam int NUM_CLASSES_DEF  = 32;

	localparam int GLYPH_COUNT   = 4;
	localparam int DIGIT_CLASSES = 9;
	localparam int NEIGH_LAST    = 4;
	localparam int ZERO_LIMIT    = 3;

	localparam logic [7:0] ASCII_ONE = 8'd49;
	localparam logic [7:0] ASCII_A   = 8'd65;

	localparam logic REQ_WEIGHT = 1'b0;
	localparam logic REQ_PIXEL  = 1'b1;

	typedef enum logic [1:0] {
		CFG_GREY_LEVEL = 2'd0,
		CFG_REGION_X   = 2'd1,
		CFG_REGION_Y   = 2'd2
	} cfg_index_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_FRD  = 6'b000010,
		S_FWT  = 6'b000100,
		S_CRD  = 6'b001000,
		S_CWT  = 6'b010000,
		S_CMP  = 6'b100000
	} seq_state_t;

	typedef struct packed {
		logic       busy;
		logic       result_valid;
		logic [6:0] char_code;
		logic [1:0] glyph_slot;
		logic       last;
	} seq_out_t;

endpackage

FILE: rtl/core/gbfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/gbfc_seq.sv
// Sequencer that filters each glyph and scores it against every class.
module gbfc_seq #(
	parameter int IMG_WIDTH    = gbfc_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT   = gbfc_pkg::IMG_HEIGHT_DEF,
	parameter int GLYPH_WIDTH  = gbfc_pkg::GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = gbfc_pkg::GLYPH_HEIGHT_DEF,
	parameter int NUM_CLASSES  = gbfc_pkg::NUM_CLASSES_DEF,
	localparam int FRAME_PIX   = IMG_WIDTH * IMG_HEIGHT,
	localparam int GLYPH_PIX   = GLYPH_WIDTH * GLYPH_HEIGHT,
	localparam int WDEPTH      = NUM_CLASSES * GLYPH_PIX,
	localparam int FAW         = $clog2(FRAME_PIX),
	localparam int PW          = $clog2(GLYPH_PIX),
	localparam int WAW         = $clog2(WDEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [3:0]         region_x,
	input  logic [3:0]         region_y,
	output logic [FAW-1:0]     bm_raddr,
	input  logic               bm_rdata,
	output logic [WAW-1:0]     w_raddr,
	input  logic [15:0]        w_rdata,
	output logic               fm_we,
	output logic [PW-1:0]      fm_waddr,
	output logic               fm_wdata,
	output logic [PW-1:0]      fm_raddr,
	input  logic               fm_rdata,
	output gbfc_pkg::seq_out_t sout
);

	localparam int XW  = $clog2(IMG_WIDTH + gbfc_pkg::GLYPH_COUNT * GLYPH_WIDTH + 32) + 1;
	localparam int YW  = $clog2(IMG_HEIGHT + GLYPH_HEIGHT + 32) + 1;
	localparam int GXW = $clog2(GLYPH_WIDTH);
	localparam int GYW = $clog2(GLYPH_HEIGHT);
	localparam int CLW = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;

	gbfc_pkg::seq_state_t state_q;
	logic [1:0]           slot_q;
	logic [2:0]           k_q;
	logic [GXW-1:0]       gx_q;
	logic [GYW-1:0]       gy_q;
	logic [PW-1:0]        px_q;
	logic [WAW-1:0]       waddr_q;
	logic [CLW-1:0]       class_q;
	logic [CLW-1:0]       best_class_q;
	logic signed [31:0]   score_q;
	logic signed [31:0]   best_q;
	logic                 oob_q;
	logic                 center_q;
	logic [2:0]           zeros_q;
	logic                 out_valid_q;
	logic [6:0]           out_code_q;
	logic [1:0]           out_slot_q;
	logic                 out_last_q;

	logic signed [XW-1:0] nx;
	logic signed [YW-1:0] ny;
	logic signed [XW-1:0] dx;
	logic signed [YW-1:0] dy;
	logic                 oob;
	logic                 nbit;
	logic [2:0]           zeros_next;
	logic signed [31:0]   wval;
	logic [7:0]           out_ascii;

	always_comb begin
		dx = '0;
		dy = '0;
		case (k_q)
			3'd1: dy = YW'(1);
			3'd2: dy = -YW'(1);
			3'd3: dx = XW'(1);
			3'd4: dx = -XW'(1);
			default: begin
				dx = '0;
				dy = '0;
			end
		endcase
	end

	assign nx = $signed(XW'(region_x) + XW'(slot_q) * XW'(GLYPH_WIDTH) + XW'(gx_q)) + dx;
	assign ny = $signed(YW'(region_y) + YW'(gy_q)) + dy;
	assign oob = nx[XW-1] || ny[YW-1] || (nx >= $signed(XW'(IMG_WIDTH)))
		|| (ny >= $signed(YW'(IMG_HEIGHT)));
	assign bm_raddr = FAW'(32'(ny) * 32'(IMG_WIDTH) + 32'(nx));

	assign nbit = !oob_q && bm_rdata;
	assign zeros_next = zeros_q + 3'(!nbit);

	assign fm_we    = (state_q == gbfc_pkg::S_FWT) && (k_q == 3'(gbfc_pkg::NEIGH_LAST));
	assign fm_waddr = px_q;
	assign fm_wdata = center_q && (zeros_next < 3'(gbfc_pkg::ZERO_LIMIT));
	assign fm_raddr = px_q;
	assign w_raddr  = waddr_q;

	assign wval = 32'($signed(w_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gbfc_pkg::S_IDLE;
			slot_q       <= '0;
			k_q          <= '0;
			gx_q         <= '0;
			gy_q         <= '0;
			px_q         <= '0;
			waddr_q      <= '0;
			class_q      <= '0;
			best_class_q <= '0;
			score_q      <= '0;
			best_q       <= {1'b1, 31'd0};
			center_q     <= 1'b0;
			zeros_q      <= '0;
			out_valid_q  <= 1'b0;
			out_code_q   <= '0;
			out_slot_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			case (state_q)
				gbfc_pkg::S_IDLE: begin
					if (go) begin
						slot_q  <= '0;
						k_q     <= '0;
						gx_q    <= '0;
						gy_q    <= '0;
						px_q    <= '0;
						state_q <= gbfc_pkg::S_FRD;
					end
				end
				gbfc_pkg::S_FRD: begin
					state_q <= gbfc_pkg::S_FWT;
				end
				gbfc_pkg::S_FWT: begin
					if (k_q == 3'd0) begin
						center_q <= nbit;
						zeros_q  <= '0;
					end else begin
						zeros_q <= zeros_next;
					end
					if (k_q == 3'(gbfc_pkg::NEIGH_LAST)) begin
						k_q <= '0;
						if (px_q == PW'(GLYPH_PIX - 1)) begin
							px_q         <= '0;
							gx_q         <= '0;
							gy_q         <= '0;
							waddr_q      <= '0;
							class_q      <= '0;
							score_q      <= '0;
							best_q       <= {1'b1, 31'd0};
							best_class_q <= '0;
							state_q      <= gbfc_pkg::S_CRD;
						end else begin
							px_q <= px_q + PW'(1);
							if (gx_q == GXW'(GLYPH_WIDTH - 1)) begin
								gx_q <= '0;
								gy_q <= gy_q + GYW'(1);
							end else begin
								gx_q <= gx_q + GXW'(1);
							end
							state_q <= gbfc_pkg::S_FRD;
						end
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= gbfc_pkg::S_FRD;
					end
				end
				gbfc_pkg::S_CRD: begin
					state_q <= gbfc_pkg::S_CWT;
				end
				gbfc_pkg::S_CWT: begin
					if (fm_rdata) begin
						score_q <= score_q + wval;
					end
					waddr_q <= waddr_q + WAW'(1);
					if (px_q == PW'(GLYPH_PIX - 1)) begin
						px_q    <= '0;
						state_q <= gbfc_pkg::S_CMP;
					end else begin
						px_q    <= px_q + PW'(1);
						state_q <= gbfc_pkg::S_CRD;
					end
				end
				gbfc_pkg::S_CMP: begin
					// A later class wins only with a strictly higher score.
					if (best_q < score_q) begin
						best_q       <= score_q;
						best_class_q <= class_q;
					end
					score_q <= '0;
					if (class_q == CLW'(NUM_CLASSES - 1)) begin
						out_valid_q <= 1'b1;
						out_code_q  <= (best_q < score_q) ? 7'(class_q) : 7'(best_class_q);
						out_slot_q  <= slot_q;
						out_last_q  <= (slot_q == 2'(gbfc_pkg::GLYPH_COUNT - 1));
						slot_q      <= slot_q + 2'd1;
						state_q     <= (slot_q == 2'(gbfc_pkg::GLYPH_COUNT - 1))
							? gbfc_pkg::S_IDLE : gbfc_pkg::S_FRD;
					end else begin
						class_q <= class_q + CLW'(1);
						state_q <= gbfc_pkg::S_CRD;
					end
				end
				default: begin
					state_q <= gbfc_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gbfc_pkg::S_FRD) begin
			oob_q <= oob;
		end
	end

	// The winning class index is held raw and mapped to ASCII on the output.
	// Classes below the digit count map to '1'..'9', the rest to 'A' onward.
	assign out_ascii = (8'(out_code_q) < 8'(gbfc_pkg::DIGIT_CLASSES))
		? 8'(out_code_q) + gbfc_pkg::ASCII_ONE
		: 8'(out_code_q) - 8'(gbfc_pkg::DIGIT_CLASSES) + gbfc_pkg::ASCII_A;

	always_comb begin
		sout.busy         = (state_q != gbfc_pkg::S_IDLE) || out_valid_q;
		sout.result_valid = out_valid_q;
		sout.char_code    = out_ascii[6:0];
		sout.glyph_slot   = out_slot_q;
		sout.last         = out_last_q;
	end

endmodule

FILE: rtl/core/glyph_binarize_filter_classify.sv
// Top level: binarizes pixels, holds the weight and bitmap stores, runs the classifier.
//
// Weight writes and pixels are accepted only while busy is low. The pixel that completes
// a frame starts the classifier, which keeps busy high while it filters and scores
// GLYPH_COUNT glyphs and presents the last result. The bitmap and weight memories each
// have a single read port. The four results come one per glyph, left to right, each on
// result_valid for one cycle; the receiver cannot stall them and must take each one as it
// appears. Configuration writes are always ready and are meant for idle periods only.
module glyph_binarize_filter_classify #(
	parameter int IMG_WIDTH    = gbfc_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT   = gbfc_pkg::IMG_HEIGHT_DEF,
	parameter int GLYPH_WIDTH  = gbfc_pkg::GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = gbfc_pkg::GLYPH_HEIGHT_DEF,
	parameter int NUM_CLASSES  = gbfc_pkg::NUM_CLASSES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [12:0] weight_index,
	input  logic signed [15:0] weight_value,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        result_valid,
	output logic [6:0]  char_code,
	output logic [1:0]  glyph_slot,
	output logic        last
);

	localparam int FRAME_PIX = IMG_WIDTH * IMG_HEIGHT;
	localparam int GLYPH_PIX = GLYPH_WIDTH * GLYPH_HEIGHT;
	localparam int WDEPTH    = NUM_CLASSES * GLYPH_PIX;
	localparam int FAW       = $clog2(FRAME_PIX);
	localparam int PW        = $clog2(GLYPH_PIX);
	localparam int WAW       = $clog2(WDEPTH);

	logic [7:0]     grey_q;
	logic [3:0]     region_x_q;
	logic [3:0]     region_y_q;
	logic [FAW-1:0] pix_cnt_q;

	logic               accept;
	logic               pix_acc;
	logic               frame_end;
	logic               ink;
	logic               w_we;
	logic [FAW-1:0]     bm_raddr;
	logic               bm_rdata;
	logic [WAW-1:0]     w_raddr;
	logic [15:0]        w_rdata;
	logic               fm_we;
	logic [PW-1:0]      fm_waddr;
	logic               fm_wdata;
	logic [PW-1:0]      fm_raddr;
	logic               fm_rdata;
	gbfc_pkg::seq_out_t sout;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign pix_acc   = accept && (req_type == gbfc_pkg::REQ_PIXEL);
	assign frame_end = pix_acc && (pix_cnt_q == FAW'(FRAME_PIX - 1));
	assign ink       = (red < grey_q) || (green < grey_q) || (blue < grey_q);
	assign w_we      = accept && (req_type == gbfc_pkg::REQ_WEIGHT)
		&& (32'(weight_index) < 32'(WDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grey_q     <= 8'd128;
			region_x_q <= 4'd1;
			region_y_q <= 4'd1;
			pix_cnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gbfc_pkg::CFG_GREY_LEVEL: grey_q     <= cfg_data;
					gbfc_pkg::CFG_REGION_X:   region_x_q <= cfg_data[3:0];
					gbfc_pkg::CFG_REGION_Y:   region_y_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (frame_end) begin
				pix_cnt_q <= '0;
			end else if (pix_acc) begin
				pix_cnt_q <= pix_cnt_q + FAW'(1);
			end
		end
	end

	gbfc_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (weight_index[WAW-1:0]),
		.wdata (weight_value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	gbfc_ram #(.WIDTH(1), .DEPTH(FRAME_PIX)) u_bitmap_ram (
		.clk   (clk),
		.we    (pix_acc),
		.waddr (pix_cnt_q),
		.wdata (ink),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	gbfc_ram #(.WIDTH(1), .DEPTH(GLYPH_PIX)) u_filt_ram (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	gbfc_seq #(
		.IMG_WIDTH    (IMG_WIDTH),
		.IMG_HEIGHT   (IMG_HEIGHT),
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.NUM_CLASSES  (NUM_CLASSES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (frame_end),
		.region_x (region_x_q),
		.region_y (region_y_q),
		.bm_raddr (bm_raddr),
		.bm_rdata (bm_rdata),
		.w_raddr  (w_raddr),
		.w_rdata  (w_rdata),
		.fm_we    (fm_we),
		.fm_waddr (fm_waddr),
		.fm_wdata (fm_wdata),
		.fm_raddr (fm_raddr),
		.fm_rdata (fm_rdata),
		.sout     (sout)
	);

	assign busy         = sout.busy;
	assign result_valid = sout.result_valid;
	assign char_code    = sout.char_code;
	assign glyph_slot   = sout.glyph_slot;
	assign last         = sout.last;

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result transfer outside a busy period");

	a_result_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(frame_end))
		else $error("busy rose without a completed frame");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !busy)
		else $error("still busy after the last glyph result");

endmodule
